FILE: rtl/tspf_pkg.sv
// Package for the TCP SYN port filter: codes, table entry layout and the
// command/status structs between controller and datapath. No dependencies.
package tspf_pkg;

   // Default table size and configuration address width.
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int CSR_ADDR_W      = 3;

   // Register index of the filter enable bit (byte address bit 2).
   localparam logic CSR_IDX_FILTER = 1'b0;

   // Item operation codes.
   localparam logic [1:0] OP_CHECK    = 2'd0;
   localparam logic [1:0] OP_RULE     = 2'd1;
   localparam logic [1:0] OP_RESPONSE = 2'd2;

   // Rule status codes.
   localparam logic [1:0] ST_ACCEPT  = 2'd0;
   localparam logic [1:0] ST_DENY    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   // Verdict codes.
   localparam logic [1:0] VERDICT_PASS = 2'd0;
   localparam logic [1:0] VERDICT_DROP = 2'd1;
   localparam logic [1:0] VERDICT_ASK  = 2'd2;

   // Bare SYN qualification constants.
   localparam logic [15:0] SYN_HDR_LEN    = 16'd14;
   localparam logic [15:0] SYN_LA_ABOVE   = 16'd40;
   localparam logic [15:0] SYN_LA_BELOW   = 16'd60;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  FLAGS_SYN      = 8'h02;

   // One rule table entry.
   typedef struct packed {
      logic [15:0] port;
      logic [1:0]  status;
      logic [31:0] src;
      logic [31:0] dst;
   } entry_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic match;
      logic done;
   } status_type;

endpackage

FILE: rtl/tcp_syn_port_filter_top.sv
// Top level of the TCP SYN port filter: configuration register and the
// controller and datapath instances. Depends on tspf_pkg, tspf_ctrl, tspf_datapath.
//
// Usage: each request beat (req_valid/req_ready) is a packet check, a port
// rule set or a user response. Each request yields exactly one response beat
// (rsp_valid/rsp_ready) with the verdict, the question for the user, and the
// found, reinject and table full flags.
// The APB-style port holds filter_enable at byte address 0; pready is always
// high and writes are meant to happen only while the block is idle.
// Scan: a request that touches the table scans the N filled slots, one
// memory read per cycle through the registered read port, stopping at the
// first hit. One item is in work at a time: the next request is accepted
// only once the controller is back in idle, after the result is registered.
// Reset empties the table by clearing its fill count and turns filtering
// off. If the receiver stalls, the response holds in its output register;
// the next request is still accepted, and its result waits until the held
// beat is taken.
module tcp_syn_port_filter_top
   import tspf_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [15:0]           req_header_len,
   input  logic [15:0]           req_lookahead_len,
   input  logic [15:0]           req_ethertype,
   input  logic [7:0]            req_ip_proto,
   input  logic [7:0]            req_tcp_flags,
   input  logic [15:0]           req_dst_port,
   input  logic [31:0]           req_src_ip,
   input  logic [31:0]           req_dst_ip,
   input  logic [1:0]            req_rule_status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_verdict,
   output logic [15:0]           rsp_ask_port,
   output logic [31:0]           rsp_ask_src_ip,
   output logic [31:0]           rsp_ask_dst_ip,
   output logic                  rsp_entry_found,
   output logic                  rsp_reinject,
   output logic                  rsp_table_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic       filter_enable_ff;
   logic       csr_write;
   cmd_type    cmd;
   status_type status;

   // Configuration register: write on the access beat.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_IDX_FILTER);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
      end else if (csr_write) begin
         filter_enable_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_FILTER) ? {31'd0, filter_enable_ff} : 32'd0;

   // Controller.
   tspf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   tspf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .filter_enable     (filter_enable_ff),
      .req_op            (req_op),
      .req_header_len    (req_header_len),
      .req_lookahead_len (req_lookahead_len),
      .req_ethertype     (req_ethertype),
      .req_ip_proto      (req_ip_proto),
      .req_tcp_flags     (req_tcp_flags),
      .req_dst_port      (req_dst_port),
      .req_src_ip        (req_src_ip),
      .req_dst_ip        (req_dst_ip),
      .req_rule_status   (req_rule_status),
      .rsp_verdict       (rsp_verdict),
      .rsp_ask_port      (rsp_ask_port),
      .rsp_ask_src_ip    (rsp_ask_src_ip),
      .rsp_ask_dst_ip    (rsp_ask_dst_ip),
      .rsp_entry_found   (rsp_entry_found),
      .rsp_reinject      (rsp_reinject),
      .rsp_table_full    (rsp_table_full)
   );

endmodule

FILE: rtl/tspf_ctrl.sv
// Controller state machine for the TCP SYN port filter.
// Depends on tspf_pkg for the state enum and the command/status structs.
module tspf_ctrl
   import tspf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match || status.done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // Finish only once the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result beat stays up until the receiver takes it.
   always_comb begin
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result only follows the update state.
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_UPDATE)
      else $error("result raised outside the update state");

   // The datapath never reports a hit and the end of the scan together.
   a_match_done_excl: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !(status.match && status.done))
      else $error("scan reported hit and end together");

endmodule

FILE: rtl/tspf_datapath.sv
// Datapath for the TCP SYN port filter: item registers, rule table memory,
// scan counter, fill count and result registers. Depends on tspf_pkg.
module tspf_datapath
   import tspf_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        filter_enable,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_header_len,
   input  logic [15:0] req_lookahead_len,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_proto,
   input  logic [7:0]  req_tcp_flags,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [1:0]  req_rule_status,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_ask_port,
   output logic [31:0] rsp_ask_src_ip,
   output logic [31:0] rsp_ask_dst_ip,
   output logic        rsp_entry_found,
   output logic        rsp_reinject,
   output logic        rsp_table_full
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Rule table. Slots are filled in order and never freed, so the slots
   // below the fill count are exactly the valid ones.
   entry_type table_mem [TABLE_DEPTH];

   // Item registers.
   logic [1:0]  op_ff;
   logic [15:0] port_ff;
   logic [31:0] sip_ff, dip_ff;
   logic [1:0]  rst_ff;
   logic        active_ff;

   // Control registers.
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  scan_addr_ff;
   logic              pend_ff;
   logic [ADDR_W-1:0] tag_ff;
   logic              hit_ff;
   logic [ADDR_W-1:0] hit_idx_ff;
   entry_type         hit_entry_ff;
   entry_type         rd_data_ff;

   // Result registers.
   logic [1:0]  verdict_ff, verdict_in;
   logic [15:0] ask_port_ff, ask_port_in;
   logic [31:0] ask_src_ff, ask_src_in;
   logic [31:0] ask_dst_ff, ask_dst_in;
   logic        found_ff, found_in;
   logic        reinj_ff, reinj_in;
   logic        full_ff, full_in;

   logic              syn;
   logic              scanning_op;
   logic [CNT_W-1:0]  limit;
   logic              entry_eq;
   logic              match;
   logic              more;
   logic              rd_issue;
   logic              tab_full;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   entry_type         mem_wdata;

   // Bare IPv4 TCP SYN qualification of the incoming beat.
   assign syn = filter_enable && (req_header_len == SYN_HDR_LEN) &&
                (req_lookahead_len > SYN_LA_ABOVE) && (req_lookahead_len < SYN_LA_BELOW) &&
                (req_ethertype == ETHERTYPE_IPV4) && (req_ip_proto == PROTO_TCP) &&
                (req_tcp_flags == FLAGS_SYN);

   // Only SYN checks, rule sets and user responses touch the table.
   assign scanning_op = ((req_op == OP_CHECK) && syn) || (req_op == OP_RULE) ||
                        (req_op == OP_RESPONSE);

   // Capture the item when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         port_ff   <= req_dst_port;
         sip_ff    <= req_src_ip;
         dip_ff    <= req_dst_ip;
         rst_ff    <= (req_rule_status == ST_INVALID) ? ST_UNKNOWN : req_rule_status;
         active_ff <= scanning_op;
      end
   end

   // Scan compare: a response also needs the source address to match.
   assign limit    = active_ff ? fill_ff : '0;
   assign entry_eq = (rd_data_ff.port == port_ff) &&
                     ((op_ff != OP_RESPONSE) || (rd_data_ff.src == sip_ff));
   assign match    = pend_ff && entry_eq;
   assign more     = scan_addr_ff < limit;
   assign rd_issue = cmd.scan && !match && more;

   assign status.match = match;
   assign status.done  = !pend_ff && !more;

   // Scan counter, read pipeline and hit capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else if (cmd.load) begin
         pend_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         pend_ff <= rd_issue;
         if (cmd.scan && match) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_addr_ff <= '0;
      end else if (rd_issue) begin
         scan_addr_ff <= scan_addr_ff + CNT_W'(1);
      end
      if (rd_issue) begin
         tag_ff <= scan_addr_ff[ADDR_W-1:0];
      end
      if (cmd.scan && match) begin
         hit_idx_ff   <= tag_ff;
         hit_entry_ff <= rd_data_ff;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_issue) begin
         rd_data_ff <= table_mem[scan_addr_ff[ADDR_W-1:0]];
      end
   end

   // Result and table update after the scan.
   assign tab_full = (fill_ff == DEPTH_CNT);

   always_comb begin
      verdict_in  = VERDICT_PASS;
      ask_port_in = '0;
      ask_src_in  = '0;
      ask_dst_in  = '0;
      found_in    = 1'b0;
      reinj_in    = 1'b0;
      full_in     = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = fill_ff[ADDR_W-1:0];
      mem_wdata   = hit_entry_ff;
      fill_in     = fill_ff;
      if (active_ff && hit_ff) begin
         found_in        = 1'b1;
         mem_waddr       = hit_idx_ff;
         mem_wdata.status = rst_ff;
         case (op_ff)
            OP_CHECK: begin
               verdict_in = (hit_entry_ff.status == ST_ACCEPT) ? VERDICT_PASS : VERDICT_DROP;
            end
            OP_RULE: begin
               mem_we = cmd.update;
            end
            OP_RESPONSE: begin
               mem_we   = cmd.update;
               reinj_in = (rst_ff == ST_ACCEPT);
            end
            default: begin
               found_in = 1'b0;
            end
         endcase
      end else if (active_ff) begin
         // Miss: a SYN check or rule set inserts at the lowest free slot.
         case (op_ff)
            OP_CHECK: begin
               if (tab_full) begin
                  verdict_in = VERDICT_DROP;
                  full_in    = 1'b1;
               end else begin
                  verdict_in  = VERDICT_ASK;
                  ask_port_in = port_ff;
                  ask_src_in  = sip_ff;
                  ask_dst_in  = dip_ff;
                  mem_we      = cmd.update;
                  mem_wdata   = '{port: port_ff, status: ST_UNKNOWN, src: sip_ff, dst: dip_ff};
                  fill_in     = fill_ff + CNT_W'(1);
               end
            end
            OP_RULE: begin
               if (tab_full) begin
                  full_in = 1'b1;
               end else begin
                  mem_we    = cmd.update;
                  mem_wdata = '{port: port_ff, status: rst_ff, src: 32'd0, dst: 32'd0};
                  fill_in   = fill_ff + CNT_W'(1);
               end
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.update) begin
         fill_ff <= fill_in;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         verdict_ff  <= verdict_in;
         ask_port_ff <= ask_port_in;
         ask_src_ff  <= ask_src_in;
         ask_dst_ff  <= ask_dst_in;
         found_ff    <= found_in;
         reinj_ff    <= reinj_in;
         full_ff     <= full_in;
      end
   end

   assign rsp_verdict     = verdict_ff;
   assign rsp_ask_port    = ask_port_ff;
   assign rsp_ask_src_ip  = ask_src_ff;
   assign rsp_ask_dst_ip  = ask_dst_ff;
   assign rsp_entry_found = found_ff;
   assign rsp_reinject    = reinj_ff;
   assign rsp_table_full  = full_ff;

   // The fill count never passes the table size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("fill count beyond table size");

   // The fill count only grows, and by one slot at a time.
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fill_ff == $past(fill_ff)) ||
                        (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("fill count jumped");

   // Reads only reach filled slots.
   a_read_filled: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (scan_addr_ff < fill_ff))
      else $error("scan read beyond filled slots");

endmodule

FILE: test/tspf_screen_monitor.sv
`timescale 1ns / 1ps
// Scoreboard for the TCP SYN port filter: watches the request, response and
// configuration ports, keeps its own rule table and checks every response beat.
// Depends on tspf_pkg.
module tspf_screen_monitor
   import tspf_pkg::*;
#(
   parameter int DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [15:0]           req_header_len,
   input  logic [15:0]           req_lookahead_len,
   input  logic [15:0]           req_ethertype,
   input  logic [7:0]            req_ip_proto,
   input  logic [7:0]            req_tcp_flags,
   input  logic [15:0]           req_dst_port,
   input  logic [31:0]           req_src_ip,
   input  logic [31:0]           req_dst_ip,
   input  logic [1:0]            req_rule_status,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [1:0]            rsp_verdict,
   input  logic [15:0]           rsp_ask_port,
   input  logic [31:0]           rsp_ask_src_ip,
   input  logic [31:0]           rsp_ask_dst_ip,
   input  logic                  rsp_entry_found,
   input  logic                  rsp_reinject,
   input  logic                  rsp_table_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    mismatches,
   output int                    outstanding
);

   localparam logic [CSR_ADDR_W-1:0] FILTER_ADDR = {CSR_IDX_FILTER, 2'b00};

   // One response beat as the filter should produce it.
   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] ask_port;
      logic [31:0] ask_src;
      logic [31:0] ask_dst;
      logic        found;
      logic        reinject;
      logic        full;
   } screen_result_type;

   entry_type         slot_entry [DEPTH];
   logic              slot_used [DEPTH];
   logic              filter_on;
   int                err_count = 0;
   screen_result_type verdict_queue [$];

   assign mismatches = err_count;

   // Lowest valid slot that holds the port, or -1.
   function automatic int find_port(input logic [15:0] port);
      for (int i = 0; i < DEPTH; i++)
         if (slot_used[i] && slot_entry[i].port == port)
            return i;
      return -1;
   endfunction

   // Lowest free slot, or -1 when the table is full.
   function automatic int find_free();
      for (int i = 0; i < DEPTH; i++)
         if (!slot_used[i])
            return i;
      return -1;
   endfunction

   // Applies one request to the rule table and returns the expected response.
   function automatic screen_result_type screen_request(
      input logic [1:0]  op,
      input logic [15:0] hlen,
      input logic [15:0] llen,
      input logic [15:0] etype,
      input logic [7:0]  proto,
      input logic [7:0]  flags,
      input logic [15:0] port,
      input logic [31:0] sip,
      input logic [31:0] dip,
      input logic [1:0]  status
   );
      screen_result_type res;
      logic [1:0]        code;
      logic              bare_syn;
      int                idx;
      res = '0;
      // An out-of-range status is kept as unknown.
      code = (status == ST_INVALID) ? ST_UNKNOWN : status;
      case (op)
         OP_CHECK: begin
            bare_syn = filter_on && hlen == SYN_HDR_LEN && llen > SYN_LA_ABOVE &&
                       llen < SYN_LA_BELOW && etype == ETHERTYPE_IPV4 &&
                       proto == PROTO_TCP && flags == FLAGS_SYN;
            if (bare_syn) begin
               idx = find_port(port);
               if (idx >= 0) begin
                  res.found = 1'b1;
                  res.verdict = (slot_entry[idx].status == ST_ACCEPT) ?
                                VERDICT_PASS : VERDICT_DROP;
               end else begin
                  idx = find_free();
                  if (idx < 0) begin
                     res.verdict = VERDICT_DROP;
                     res.full = 1'b1;
                  end else begin
                     slot_used[idx] = 1'b1;
                     slot_entry[idx] = '{port: port, status: ST_UNKNOWN, src: sip, dst: dip};
                     res.verdict = VERDICT_ASK;
                     res.ask_port = port;
                     res.ask_src = sip;
                     res.ask_dst = dip;
                  end
               end
            end
         end
         OP_RULE: begin
            idx = find_port(port);
            if (idx >= 0) begin
               res.found = 1'b1;
               slot_entry[idx].status = code;
            end else begin
               idx = find_free();
               if (idx < 0) begin
                  res.full = 1'b1;
               end else begin
                  slot_used[idx] = 1'b1;
                  slot_entry[idx] = '{port: port, status: code, src: '0, dst: '0};
               end
            end
         end
         OP_RESPONSE: begin
            // A user answer has to match both the port and the asking source.
            for (int i = 0; i < DEPTH && !res.found; i++) begin
               if (slot_used[i] && slot_entry[i].port == port &&
                   slot_entry[i].src == sip) begin
                  res.found = 1'b1;
                  slot_entry[i].status = code;
                  res.reinject = (code == ST_ACCEPT);
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   // Snoop all three ports at each edge; response beats are checked first.
   always @(posedge clock) begin : watch
      screen_result_type want;
      if (reset) begin
         filter_on = 1'b0;
         for (int i = 0; i < DEPTH; i++)
            slot_used[i] = 1'b0;
         verdict_queue.delete();
         outstanding <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == FILTER_ADDR)
            filter_on = pwdata[0];
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: response beat with nothing expected, verdict %0h",
                        $time, rsp_verdict);
               err_count++;
            end else begin
               want = verdict_queue.pop_front();
               check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               check_field("ask_port", 32'(want.ask_port), 32'(rsp_ask_port));
               check_field("ask_src_ip", want.ask_src, rsp_ask_src_ip);
               check_field("ask_dst_ip", want.ask_dst, rsp_ask_dst_ip);
               check_field("entry_found", 32'(want.found), 32'(rsp_entry_found));
               check_field("reinject", 32'(want.reinject), 32'(rsp_reinject));
               check_field("table_full", 32'(want.full), 32'(rsp_table_full));
            end
         end
         if (req_valid && req_ready)
            verdict_queue.push_back(screen_request(req_op, req_header_len,
               req_lookahead_len, req_ethertype, req_ip_proto, req_tcp_flags,
               req_dst_port, req_src_ip, req_dst_ip, req_rule_status));
         outstanding <= verdict_queue.size();
      end
   end

endmodule

FILE: test/tcp_syn_port_filter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the TCP SYN port filter: clock, reset, request and
// configuration stimulus, and the final verdict. Depends on tspf_pkg,
// tcp_syn_port_filter_top and tspf_screen_monitor.
module tcp_syn_port_filter_top_tb
   import tspf_pkg::*;
();

   localparam logic [1:0]            OP_UNDEFINED    = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] FILTER_ADDR     = {CSR_IDX_FILTER, 2'b00};
   localparam int                    POOL_PORTS      = 96;
   localparam int                    PHASES          = 6;
   localparam int                    ITEMS_PER_PHASE = 275;
   localparam int                    CYCLE_LIMIT     = 1200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = '0;
   logic [15:0]           req_header_len = '0;
   logic [15:0]           req_lookahead_len = '0;
   logic [15:0]           req_ethertype = '0;
   logic [7:0]            req_ip_proto = '0;
   logic [7:0]            req_tcp_flags = '0;
   logic [15:0]           req_dst_port = '0;
   logic [31:0]           req_src_ip = '0;
   logic [31:0]           req_dst_ip = '0;
   logic [1:0]            req_rule_status = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_verdict;
   logic [15:0]           rsp_ask_port;
   logic [31:0]           rsp_ask_src_ip;
   logic [31:0]           rsp_ask_dst_ip;
   logic                  rsp_entry_found;
   logic                  rsp_reinject;
   logic                  rsp_table_full;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;
   int                    mismatches;
   int                    outstanding;
   int                    cycle_count = 0;
   logic                  calm = 1'b0;
   logic [15:0]           port_pool [POOL_PORTS];
   logic [31:0]           src_pool [4];

   tcp_syn_port_filter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_header_len    (req_header_len),
      .req_lookahead_len (req_lookahead_len),
      .req_ethertype     (req_ethertype),
      .req_ip_proto      (req_ip_proto),
      .req_tcp_flags     (req_tcp_flags),
      .req_dst_port      (req_dst_port),
      .req_src_ip        (req_src_ip),
      .req_dst_ip        (req_dst_ip),
      .req_rule_status   (req_rule_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_ask_port      (rsp_ask_port),
      .rsp_ask_src_ip    (rsp_ask_src_ip),
      .rsp_ask_dst_ip    (rsp_ask_dst_ip),
      .rsp_entry_found   (rsp_entry_found),
      .rsp_reinject      (rsp_reinject),
      .rsp_table_full    (rsp_table_full),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   tspf_screen_monitor screen_mon (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side stalls at random except during the calm stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(99) < 6) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Presents one request beat, holds it until accepted, then maybe idles.
   task automatic send_item(input logic [1:0] op, input logic [15:0] hlen, llen, etype,
                            input logic [7:0] proto, flags, input logic [15:0] port,
                            input logic [31:0] sip, dip, input logic [1:0] status);
      req_valid <= 1'b1;
      req_op <= op;
      req_header_len <= hlen;
      req_lookahead_len <= llen;
      req_ethertype <= etype;
      req_ip_proto <= proto;
      req_tcp_flags <= flags;
      req_dst_port <= port;
      req_src_ip <= sip;
      req_dst_ip <= dip;
      req_rule_status <= status;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
   endtask

   // A well-formed bare SYN toward the given port.
   task automatic send_syn(input logic [15:0] port, input logic [31:0] sip, dip);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'($urandom_range(41, 59)), ETHERTYPE_IPV4,
                PROTO_TCP, FLAGS_SYN, port, sip, dip, 2'($urandom));
   endtask

   // Stops sending and waits until every response beat has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Setup and access cycles of one register write.
   task automatic write_filter(input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= FILTER_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Mostly bare SYNs and table updates on a small port set, so that entries
   // get hit, answered and the table fills up; the rest is noise.
   task automatic send_random_item();
      int          pick;
      logic [15:0] port;
      logic [31:0] sip;
      logic [15:0] hlen, llen, etype;
      logic [7:0]  proto, flags;
      port = port_pool[$urandom_range(POOL_PORTS - 1)];
      sip = ($urandom_range(4) == 0) ? $urandom : src_pool[$urandom_range(3)];
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_syn(port, sip, $urandom);
      end else if (pick < 60) begin
         send_item(OP_RULE, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), port, $urandom, $urandom, 2'($urandom));
      end else if (pick < 75) begin
         send_item(OP_RESPONSE, 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 8'($urandom), port, sip, $urandom, 2'($urandom));
      end else if (pick < 80) begin
         send_item(OP_UNDEFINED, 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 8'($urandom), 16'($urandom), $urandom, $urandom,
                   2'($urandom));
      end else if (pick < 90) begin
         // A SYN spoiled in exactly one qualifying field.
         hlen = SYN_HDR_LEN;
         llen = 16'($urandom_range(41, 59));
         etype = ETHERTYPE_IPV4;
         proto = PROTO_TCP;
         flags = FLAGS_SYN;
         case ($urandom_range(4))
            0: hlen = hlen ^ (16'h1 << $urandom_range(15));
            1: llen = $urandom_range(1) ? (SYN_LA_ABOVE - 16'($urandom_range(40)))
                                        : (SYN_LA_BELOW + 16'($urandom));
            2: etype = etype ^ (16'h1 << $urandom_range(15));
            3: proto = proto ^ (8'h1 << $urandom_range(7));
            default: flags = flags ^ (8'h1 << $urandom_range(7));
         endcase
         send_item(OP_CHECK, hlen, llen, etype, proto, flags, port, sip, $urandom,
                   2'($urandom));
      end else begin
         send_item(OP_CHECK, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), 16'($urandom), $urandom, $urandom, 2'($urandom));
      end
   endtask

   initial begin : stimulus
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_PORTS; i++)
         port_pool[i] = 16'($urandom);
      src_pool[0] = 32'h0;
      src_pool[1] = 32'hFFFF_FFFF;
      src_pool[2] = $urandom;
      src_pool[3] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Filtering is off after reset: a SYN passes, but rules still land.
      send_syn(16'd80, 32'hC0A8_0001, 32'h0A00_0002);
      send_item(OP_RULE, '0, '0, '0, '0, '0, 16'd443, 32'h1234, 32'h5678, ST_ACCEPT);
      wait_idle();
      write_filter(32'h1);

      // Ask, then drop while unknown, then answer and pass.
      send_syn(16'd80, 32'hC0A8_0001, 32'h0A00_0002);
      send_syn(16'd80, 32'hC0A8_0009, 32'h0A00_0003);
      send_item(OP_RESPONSE, '0, '0, '0, '0, '0, 16'd80, 32'hC0A8_0001, '0, ST_ACCEPT);
      send_syn(16'd80, 32'hC0A8_0001, 32'h0A00_0002);
      send_item(OP_RESPONSE, '0, '0, '0, '0, '0, 16'd80, 32'hC0A8_0002, '0, ST_DENY);

      // Rule insert with zero addresses, deny, status three and accept.
      send_item(OP_RULE, '0, '0, '0, '0, '0, 16'd22, '1, '1, ST_DENY);
      send_syn(16'd22, 32'h0A0A_0A0A, 32'h0B0B_0B0B);
      send_item(OP_RULE, '0, '0, '0, '0, '0, 16'd22, '0, '0, ST_INVALID);
      send_item(OP_RESPONSE, '0, '0, '0, '0, '0, 16'd22, 32'h0, '0, ST_INVALID);
      send_item(OP_RULE, '0, '0, '0, '0, '0, 16'd22, '0, '0, ST_ACCEPT);
      send_syn(16'd22, 32'h0A0A_0A0A, 32'h0B0B_0B0B);
      send_syn(16'd443, 32'h1111_1111, 32'h2222_2222);

      // Undefined operation with every bit set.
      send_item(OP_UNDEFINED, '1, '1, '1, '1, '1, '1, '1, '1, '1);

      // Qualification edges: lengths just inside and outside, wrong type bits.
      send_item(OP_CHECK, 16'd13, 16'd50, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN, 16'd7,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, 16'd15, 16'd50, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN, 16'd7,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd40, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN,
                16'd7, 32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd60, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN,
                16'd7, 32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd41, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN,
                16'd0, 32'h0, 32'h0, ST_DENY);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd59, ETHERTYPE_IPV4, PROTO_TCP, FLAGS_SYN,
                16'hFFFF, '1, '1, ST_INVALID);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd50, 16'h0801, PROTO_TCP, FLAGS_SYN, 16'd9,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd50, ETHERTYPE_IPV4, 8'd17, FLAGS_SYN, 16'd9,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd50, ETHERTYPE_IPV4, PROTO_TCP, 8'h12, 16'd9,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, SYN_HDR_LEN, 16'd50, ETHERTYPE_IPV4, PROTO_TCP, 8'h03, 16'd9,
                32'h1, 32'h2, ST_ACCEPT);
      send_item(OP_CHECK, '1, '1, '1, '1, '1, '1, '1, '1, '1);

      // Random phases under changing filter settings; the third one runs calm.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         write_filter(($urandom & ~32'h1) | ((phase == 1 || phase == 4) ? 32'h0 : 32'h1));
         calm <= (phase == 2);
         repeat (ITEMS_PER_PHASE) send_random_item();
      end

      wait_idle();
      repeat (80) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
rtl/tspf_pkg.sv
rtl/tspf_ctrl.sv
rtl/tspf_datapath.sv
rtl/tcp_syn_port_filter_top.sv
test/tspf_screen_monitor.sv
test/tcp_syn_port_filter_top_tb.sv
